@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the sorted-set block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MES_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define MES_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ sv/mes_pkg.sv @@
// ----------------------------------------------------------------------------
// mes_pkg
// Types and constants for the sorted-set median/min/max extractor.
// ----------------------------------------------------------------------------
package mes_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_MIN    = 2'd1,
    CMD_MAX    = 2'd2,
    CMD_MEDIAN = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [1:0]              status;
  } out_t;

  // Broadcast control from the controller to every cell
  typedef struct packed {
    logic                    ins;    // insert key at its sorted place
    logic                    ext;    // remove element at idx
    logic [IDX_W-1:0]        idx;    // element to remove / read out
    logic [CNT_W-1:0]        count;  // current number of held values
    logic signed [VAL_W-1:0] key;    // value offered by an insert
  } cell_ctrl_t;

endpackage

@@ sv/mes_cell.sv @@
// ----------------------------------------------------------------------------
// mes_cell
// One slot of the sorted row: holds a value, compares it with the broadcast
// key and shifts right on insert or left on extract.
// ----------------------------------------------------------------------------
module mes_cell (
  input  logic                            clk_i,
  input  logic [mes_pkg::IDX_W-1:0]       pos_i,
  input  mes_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [mes_pkg::VAL_W-1:0] left_val_i,
  input  logic                            left_lt_i,
  input  logic signed [mes_pkg::VAL_W-1:0] right_val_i,
  output logic signed [mes_pkg::VAL_W-1:0] val_o,
  output logic                            lt_o,
  output logic                            eq_o,
  output logic signed [mes_pkg::VAL_W-1:0] tap_o
);

  logic signed [mes_pkg::VAL_W-1:0] val_q, val_d;
  logic                             occ;

  // Slot holds a live element when it lies below the fill count
  assign occ  = {1'b0, pos_i} < ctrl_i.count;
  assign lt_o = occ && (val_q < ctrl_i.key);
  assign eq_o = occ && (val_q == ctrl_i.key);

  // Read-out tap, OR-combined across the row
  assign tap_o = (occ && (pos_i == ctrl_i.idx)) ? val_q : '0;
  assign val_o = val_q;

  // Insert: smaller values stay, the first slot not holding a smaller value takes
  // the key, the rest take their left neighbor. Extract: slots from idx up pull right.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (!lt_o) begin
        val_d = left_lt_i ? ctrl_i.key : left_val_i;
      end
    end else if (ctrl_i.ext && (pos_i >= ctrl_i.idx)) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ sv/median_extract_sorted_set.sv @@
// ----------------------------------------------------------------------------
// median_extract_sorted_set
// Sorted set of distinct signed values with extract min / max / lower median.
// ----------------------------------------------------------------------------
// Usage: an input item (command, value) is taken on in_valid_i & in_ready_o.
// Commands: insert, extract minimum, extract maximum, extract lower median
// (element (count-1)/2). Every item gives exactly one result item
// (result_value, status) on the output channel, taken on out_valid_o &
// out_ready_i.
// Output: the result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken. Each command is one compare-and-shift
// step across the row of CAPACITY cells, all cells acting in parallel.
// Stall: the result sits in an output register; a new item is accepted in
// the same cycle the waiting result is taken, otherwise the input stalls.
// Reset: the fill count clears, so the set starts empty; cell contents are
// left as they are and never read before being written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module median_extract_sorted_set (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mes_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mes_pkg::out_t  out_data_o
);

  localparam int unsigned N = mes_pkg::CAPACITY;

  logic                             in_fire;
  logic [mes_pkg::CNT_W-1:0]        count_q, count_d;
  logic [mes_pkg::CNT_W-1:0]        count_m1;
  logic                             out_valid_q;
  mes_pkg::out_t                    out_q, out_d;
  mes_pkg::cell_ctrl_t              ctrl;
  logic                             is_ins, dup, full, empty;

  logic signed [mes_pkg::VAL_W-1:0] val_w [N];
  logic signed [mes_pkg::VAL_W-1:0] tap_w [N];
  logic [N-1:0]                     lt_w;
  logic [N-1:0]                     eq_w;
  logic signed [mes_pkg::VAL_W-1:0] tap_or;

  // Handshake: accept whenever the output slot is free or being drained
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Command decode
  assign is_ins   = (in_data_i.command == mes_pkg::CMD_INSERT);
  assign dup      = |eq_w;
  assign full     = (count_q == mes_pkg::CNT_W'(N));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - mes_pkg::CNT_W'(1);

  always_comb begin
    ctrl       = '0;
    ctrl.key   = in_data_i.value;
    ctrl.count = count_q;
    ctrl.ins   = in_fire && is_ins && !dup && !full;
    ctrl.ext   = in_fire && !is_ins && !empty;
    unique case (in_data_i.command)
      mes_pkg::CMD_MAX:    ctrl.idx = count_m1[mes_pkg::IDX_W-1:0];
      mes_pkg::CMD_MEDIAN: ctrl.idx = count_m1[mes_pkg::IDX_W:1];
      default:             ctrl.idx = '0;
    endcase
  end

  // Row of cells
  for (genvar g = 0; g < N; g++) begin : gen_cell
    logic signed [mes_pkg::VAL_W-1:0] left_val, right_val;
    logic                             left_lt;
    if (g == 0) begin : gen_head
      assign left_val = '0;
      assign left_lt  = 1'b1;
    end else begin : gen_mid
      assign left_val = val_w[g-1];
      assign left_lt  = lt_w[g-1];
    end
    if (g == N - 1) begin : gen_tail
      assign right_val = '0;
    end else begin : gen_body
      assign right_val = val_w[g+1];
    end

    mes_cell u_cell (
      .clk_i       (clk_i),
      .pos_i       (mes_pkg::IDX_W'(g)),
      .ctrl_i      (ctrl),
      .left_val_i  (left_val),
      .left_lt_i   (left_lt),
      .right_val_i (right_val),
      .val_o       (val_w[g]),
      .lt_o        (lt_w[g]),
      .eq_o        (eq_w[g]),
      .tap_o       (tap_w[g])
    );
  end

  // Read-out bus: at most one cell drives a non-zero tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < N; i++) begin
      tap_or = tap_or | tap_w[i];
    end
  end

  // Result and count update
  always_comb begin
    out_d   = '0;
    count_d = count_q;
    if (is_ins) begin
      if (dup) begin
        out_d.status = mes_pkg::ST_DUP;
      end else if (full) begin
        out_d.status = mes_pkg::ST_FULL;
      end else begin
        out_d.status = mes_pkg::ST_OK;
        count_d      = count_q + mes_pkg::CNT_W'(1);
      end
    end else if (empty) begin
      out_d.status = mes_pkg::ST_EMPTY;
    end else begin
      out_d.status       = mes_pkg::ST_OK;
      out_d.result_value = tap_or;
      count_d            = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  // Checks
  `MES_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > mes_pkg::CNT_W'(N))
  `MES_ASSERT(a_empty_extract, clk_i, rst_ni,
    in_fire && !is_ins && empty |=> out_valid_q && out_q.status == mes_pkg::ST_EMPTY)
  `MES_ASSERT(a_insert_zero, clk_i, rst_ni,
    in_fire && is_ins |=> out_q.result_value == '0)
  `MES_ASSERT(a_count_step, clk_i, rst_ni,
    !in_fire |=> $stable(count_q))

endmodule

@@ bench/sorted_set_checker.sv @@
// ----------------------------------------------------------------------------
// sorted_set_checker
// Watches both channels of the sorted-set extractor. Every accepted command
// is applied to a private sorted set to work out its result; every accepted
// result is compared field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sorted_set_checker
  import mes_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   mismatch_count_o,
  output int   pending_count_o
);

  // Values held by the block, ascending, and results still owed
  logic signed [VAL_W-1:0] held_values[$];
  out_t                    owed_results[$];
  out_t                    want;
  int                      mismatches = 0;
  int                      owed = 0;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = owed;

  // Apply one command to the set and return the result it must produce
  function automatic out_t apply_command(in_t item);
    out_t res;
    int   pos;
    int   idx;
    res.result_value = '0;
    res.status       = ST_OK;
    case (cmd_e'(item.command))
      CMD_INSERT: begin
        pos = 0;
        while (pos < held_values.size() && held_values[pos] < $signed(item.value))
          pos++;
        if (pos < held_values.size() && held_values[pos] == $signed(item.value))
          res.status = ST_DUP;
        else if (held_values.size() >= CAPACITY)
          res.status = ST_FULL;
        else
          held_values.insert(pos, item.value);
      end
      default: begin
        if (held_values.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          case (cmd_e'(item.command))
            CMD_MIN: idx = 0;
            CMD_MAX: idx = held_values.size() - 1;
            default: idx = (held_values.size() - 1) / 2;  // lower median
          endcase
          res.result_value = held_values[idx];
          held_values.delete(idx);
        end
      end
    endcase
    return res;
  endfunction

  // Results are checked before the same edge's command is applied: a result
  // always belongs to a command taken at an earlier edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_values.delete();
      owed_results.delete();
      owed = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with none owed: value %0d status %0d", $time,
                   out_data_i.result_value, out_data_i.status);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_data_i.result_value !== want.result_value) begin
            $display("%0t: result_value expected %0d got %0d", $time,
                     want.result_value, out_data_i.result_value);
            mismatches++;
          end
          if (out_data_i.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time,
                     want.status, out_data_i.status);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        owed_results.push_back(apply_command(in_data_i));
      owed = owed_results.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the sorted-set extractor with a short directed run over empty,
// duplicate and extreme values, then phases of random commands that fill,
// churn and drain the set. The receiver stalls at random and once holds off
// long enough to back up the input. The checker does all prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import mes_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 6;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;
  int   mismatch_count;
  int   pending_count;
  int   cycle_count = 0;
  int   rx_cycle = 0;

  median_extract_sorted_set uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  sorted_set_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // 20-unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Receiver: long hold-off while items keep coming, a quiet stretch, else
  // random stalls
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 400 && rx_cycle < 700)
      out_ready_i <= 1'b0;
    else if (rx_cycle >= 900 && rx_cycle < 1200)
      out_ready_i <= 1'b1;
    else
      out_ready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Offer one item, called at a falling edge; returns at the falling edge
  // after acceptance with valid still high
  task automatic send_command(cmd_e cmd, logic signed [VAL_W-1:0] value,
                              bit allow_gap);
    in_t item;
    item.command = cmd;
    item.value   = value;
    while (allow_gap && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Extremes, a small pool that provokes duplicates, or anything
  function automatic logic signed [VAL_W-1:0] pick_value(bit narrow);
    logic signed [VAL_W-1:0] v;
    if (narrow) return int'($urandom_range(0, 80)) - 40;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 80)) - 40;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Stimulus and verdict
  initial begin
    int   insert_pct;
    int   phase;
    cmd_e cmd;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extracts from an empty set
    send_command(CMD_MIN, $urandom(), 1'b1);
    send_command(CMD_MAX, $urandom(), 1'b1);
    send_command(CMD_MEDIAN, $urandom(), 1'b1);
    // Extremes and duplicates
    send_command(CMD_INSERT, 32'sh7fff_ffff, 1'b1);
    send_command(CMD_INSERT, 32'sh8000_0000, 1'b1);
    send_command(CMD_INSERT, 0, 1'b1);
    send_command(CMD_INSERT, 0, 1'b1);
    send_command(CMD_INSERT, -1, 1'b1);
    send_command(CMD_INSERT, 1, 1'b1);
    send_command(CMD_INSERT, 32'sh7fff_ffff, 1'b1);
    send_command(CMD_INSERT, 32'sh8000_0000, 1'b1);
    send_command(CMD_INSERT, 32'sh5555_5555, 1'b1);
    send_command(CMD_INSERT, 32'shaaaa_aaaa, 1'b1);
    // Extract value field is don't-care; vary it
    send_command(CMD_MEDIAN, 32'shffff_ffff, 1'b1);
    send_command(CMD_MEDIAN, 32'sh0000_0000, 1'b1);
    send_command(CMD_MIN, 32'sh5555_5555, 1'b1);
    send_command(CMD_MAX, 32'shaaaa_aaaa, 1'b1);
    send_command(CMD_MEDIAN, $urandom(), 1'b1);
    send_command(CMD_MAX, $urandom(), 1'b1);
    send_command(CMD_MIN, $urandom(), 1'b1);
    send_command(CMD_MEDIAN, $urandom(), 1'b1);
    send_command(CMD_MIN, $urandom(), 1'b1);

    // Random phases: fill to full, churn, drain, fill from a narrow pool
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 150) % 4;
      case (phase)
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        2:       insert_pct = 15;
        default: insert_pct = 85;
      endcase
      if ($urandom_range(0, 99) < insert_pct)
        cmd = CMD_INSERT;
      else
        cmd = cmd_e'($urandom_range(1, 3));
      send_command(cmd, pick_value(phase == 3), !(n >= 700 && n < 950));
    end
    in_valid_i <= 1'b0;

    // Drain, then allow time for anything stray
    while (pending_count != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/mes_pkg.sv
sv/mes_cell.sv
sv/median_extract_sorted_set.sv
bench/sorted_set_checker.sv
bench/tb_top.sv
